[rtl/core/lis_pkg.sv]
// ----------------------------------------------------------------------------
// LED indicator priority select - shared types and constants
// Request kinds, result record, stored light sources and queue sizing.
// ----------------------------------------------------------------------------
package lis_pkg;

   // request kinds; codes 5..7 carry no meaning and are dropped
   typedef enum logic [2:0] {
      FUNC_BACKLIGHT = 3'd0,
      FUNC_BUTTONS   = 3'd1,
      FUNC_BATTERY   = 3'd2,
      FUNC_NOTIFY    = 3'd3,
      FUNC_ATTENTION = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      TARGET_DISPLAY = 2'd0,
      TARGET_BUTTONS = 2'd1,
      TARGET_LED     = 2'd2
   } target_type;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_SOLID   = 2'd1,
      MODE_BLINK   = 2'd2,
      MODE_STORED  = 2'd3
   } led_mode_type;

   localparam logic [3:0] PATTERN_BATT_RED   = 4'd3;
   localparam logic [3:0] PATTERN_BATT_OTHER = 4'd5;
   localparam logic [3:0] PATTERN_NOTIFY_GRN = 4'd7;
   localparam logic [3:0] PATTERN_ATTENTION  = 4'd14;

   localparam logic [7:0]  LEVEL_FULL = 8'hFF;
   localparam logic [31:0] RGB_MASK   = 32'h00FF_FFFF;

   // result queue sizing
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned COUNT_W    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [31:0] color;
      logic        timed;
      logic [15:0] on_ms;
      logic [15:0] off_ms;
   } source_type;

   typedef struct packed {
      source_type battery;
      source_type notify;
      source_type attention;
      logic       display_lit;
   } store_type;

   typedef struct packed {
      target_type   target;
      logic [7:0]   level;
      led_mode_type led_mode;
      logic [3:0]   pattern_id;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      logic [31:0]  blink_color;
      logic [15:0]  blink_on_ms;
      logic [15:0]  blink_off_ms;
      logic         last;
   } result_type;

   localparam result_type RESULT_ZERO = '0;

endpackage

[rtl/core/lis_source_store.sv]
// ----------------------------------------------------------------------------
// LED indicator priority select - source store
// Holds the last battery, notification and attention requests and the
// display-lit flag; exports the next values only.
// ----------------------------------------------------------------------------
module lis_source_store (
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  logic [2:0]          func,
   input  lis_pkg::source_type req_source,
   output lis_pkg::store_type  store_in
);
   import lis_pkg::*;

   store_type store_ff;

   always_comb begin
      store_in = store_ff;
      if (update) begin
         unique case (func)
            FUNC_BACKLIGHT: store_in.display_lit = |req_source.color[23:16];
            FUNC_BATTERY:   store_in.battery     = req_source;
            FUNC_NOTIFY:    store_in.notify      = req_source;
            FUNC_ATTENTION: store_in.attention   = req_source;
            default:        store_in = store_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff             <= '0;
         store_ff.display_lit <= 1'b1;
      end else begin
         store_ff <= store_in;
      end
   end

endmodule

[rtl/core/lis_led_select.sv]
// ----------------------------------------------------------------------------
// LED indicator priority select - LED command select
// Picks the lit source of highest priority and forms one RGB LED command.
// ----------------------------------------------------------------------------
module lis_led_select (
   input  lis_pkg::store_type  store,
   output lis_pkg::result_type led_result
);
   import lis_pkg::*;

   logic       att_lit;
   logic       ntf_lit;
   logic       bat_sel;
   source_type src;
   logic [7:0] r;
   logic [7:0] g;
   logic [7:0] b;

   assign att_lit = |(store.attention.color & RGB_MASK);
   assign ntf_lit = |(store.notify.color & RGB_MASK);
   assign bat_sel = !att_lit && !ntf_lit && !store.display_lit
                    && |(store.battery.color & RGB_MASK);

   always_comb begin
      if (att_lit)      src = store.attention;
      else if (ntf_lit) src = store.notify;
      else if (bat_sel) src = store.battery;
      else              src = '0;
   end

   assign r = src.color[23:16];
   assign g = src.color[15:8];
   assign b = src.color[7:0];

   always_comb begin
      led_result        = RESULT_ZERO;
      led_result.target = TARGET_LED;
      led_result.last   = 1'b1;
      if (bat_sel) begin
         led_result.led_mode   = MODE_STORED;
         led_result.pattern_id = (r > g && r > b) ? PATTERN_BATT_RED : PATTERN_BATT_OTHER;
      end else if (att_lit) begin
         led_result.led_mode   = MODE_STORED;
         led_result.pattern_id = PATTERN_ATTENTION;
      end else if (ntf_lit && g != 8'd0 && g >= r && g >= b) begin
         led_result.led_mode   = MODE_STORED;
         led_result.pattern_id = PATTERN_NOTIFY_GRN;
      end else if (r == 8'd0 && g == 8'd0 && b == 8'd0) begin
         led_result.led_mode = MODE_OFF;
      end else if (src.timed && src.on_ms != 16'd0 && src.off_ms != 16'd0) begin
         led_result.led_mode     = MODE_BLINK;
         led_result.blink_color  = src.color;
         led_result.blink_on_ms  = src.on_ms;
         led_result.blink_off_ms = src.off_ms;
      end else begin
         led_result.led_mode = MODE_SOLID;
         led_result.red      = r;
         led_result.green    = g;
         led_result.blue     = b;
      end
   end

endmodule

[rtl/core/lis_result_fifo.sv]
// ----------------------------------------------------------------------------
// LED indicator priority select - result queue
// Small register queue: up to two results in per cycle, one out while ready.
// ----------------------------------------------------------------------------
module lis_result_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push_one,
   input  logic                              push_two,
   input  lis_pkg::result_type               entry0,
   input  lis_pkg::result_type               entry1,
   input  logic                              pop_ready,
   output logic                              head_valid,
   output lis_pkg::result_type               head,
   output logic [lis_pkg::COUNT_W-1:0]       count
);
   import lis_pkg::*;

   result_type         mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [1:0]         push_cnt;
   logic               pop;

   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign pop        = head_valid && pop_ready;
   assign push_cnt   = push_two ? 2'd2 : (push_one ? 2'd1 : 2'd0);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + COUNT_W'(push_cnt) - COUNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_one || push_two) begin
         mem_ff[wr_ptr_ff] <= entry0;
      end
      if (push_two) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= entry1;
      end
   end

endmodule

[rtl/core/led_indicator_priority_select.sv]
// ----------------------------------------------------------------------------
// LED indicator priority select - top level
// Takes light requests, keeps the indicator sources and issues backlight,
// button and RGB LED commands in priority order.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser      | tlast
//  req_    | in  | color, timed, on ms, off ms        | func       | -
//  rsp_    | out | level, mode, pattern, rgb, blink   | target     | last
//
// Order: a request is registered in the input register on acceptance; its
// results are then written into the result queue, which drives rsp_tvalid.
// Backlight requests give two results, others one, unknown kinds none; the
// sustained rate is one request per cycle while rsp_tready stays high, lower
// for backlight requests, set by the single-read result queue.
// Reset: synchronous; sources clear to zero, display counts as lit, queue empty.
// Stalls: the input stage holds while the queue (4 entries) lacks room for the
// registered request's results; req_tready does not depend on rsp_tready.
// ----------------------------------------------------------------------------
module led_indicator_priority_select (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // argb_color[31:0], flash_timed[32],
                                     // flash_on_ms[48:33], flash_off_ms[64:49], zero pad
   input  logic [2:0]   req_tuser,   // func[2:0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // level[7:0], led_mode[9:8], pattern_id[13:10],
                                     // red[21:14], green[29:22], blue[37:30],
                                     // blink_color[69:38], blink_on_ms[85:70],
                                     // blink_off_ms[101:86], zero pad
   output logic [1:0]   rsp_tuser,   // target[1:0]
   output logic         rsp_tlast    // last result of a request
);
   import lis_pkg::*;

   // input register
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [2:0]         s1_func_ff;
   source_type         s1_src_ff;
   logic               req_accept;
   logic               s1_advance;
   logic               s1_fits;

   store_type          store_in;
   result_type         led_result;
   result_type         entry0;
   result_type         entry1;
   logic               push_one;
   logic               push_two;
   result_type         head;
   logic [COUNT_W-1:0] fifo_count;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign s1_advance = s1_valid_ff && s1_fits;

   // room check uses the registered count only, keeping ready free of rsp_tready
   always_comb begin
      unique case (s1_func_ff) inside
         FUNC_BACKLIGHT: s1_fits = fifo_count <= COUNT_W'(FIFO_DEPTH - 2);
         FUNC_BUTTONS,
         FUNC_BATTERY,
         FUNC_NOTIFY,
         FUNC_ATTENTION: s1_fits = fifo_count <= COUNT_W'(FIFO_DEPTH - 1);
         default:        s1_fits = 1'b1;
      endcase
   end

   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff       <= req_tuser;
         s1_src_ff.color  <= req_tdata[31:0];
         s1_src_ff.timed  <= req_tdata[32];
         s1_src_ff.on_ms  <= req_tdata[48:33];
         s1_src_ff.off_ms <= req_tdata[64:49];
      end
   end

   lis_source_store u_store (
      .clock      (clock),
      .reset      (reset),
      .update     (s1_advance),
      .func       (s1_func_ff),
      .req_source (s1_src_ff),
      .store_in   (store_in)
   );

   // LED command sees the sources with this request already applied
   lis_led_select u_led_select (
      .store      (store_in),
      .led_result (led_result)
   );

   // result build
   always_comb begin
      entry0   = led_result;
      entry1   = led_result;
      push_one = 1'b0;
      push_two = 1'b0;
      unique case (s1_func_ff) inside
         FUNC_BACKLIGHT: begin
            entry0        = RESULT_ZERO;
            entry0.target = TARGET_DISPLAY;
            entry0.level  = s1_src_ff.color[23:16];
            push_two      = s1_advance;
         end
         FUNC_BUTTONS: begin
            entry0        = RESULT_ZERO;
            entry0.target = TARGET_BUTTONS;
            entry0.level  = |(s1_src_ff.color & RGB_MASK) ? LEVEL_FULL : 8'd0;
            entry0.last   = 1'b1;
            push_one      = s1_advance;
         end
         FUNC_BATTERY,
         FUNC_NOTIFY,
         FUNC_ATTENTION: begin
            push_one = s1_advance;
         end
         default: begin
            push_one = 1'b0;
         end
      endcase
   end

   lis_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_one   (push_one),
      .push_two   (push_two),
      .entry0     (entry0),
      .entry1     (entry1),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .count      (fifo_count)
   );

   assign rsp_tuser = head.target;
   assign rsp_tlast = head.last;
   assign rsp_tdata = {2'b00, head.blink_off_ms, head.blink_on_ms, head.blink_color,
                       head.blue, head.green, head.red, head.pattern_id,
                       head.led_mode, head.level};

`ifndef NO_ASSERTIONS
   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      fifo_count <= COUNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // a backlight transaction only moves on with room for both results
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_func_ff == FUNC_BACKLIGHT)
         |-> fifo_count <= COUNT_W'(FIFO_DEPTH - 2))
      else $error("backlight pushed without room");

   // only the display write is a non-final result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> rsp_tuser == TARGET_DISPLAY)
      else $error("non-final result on wrong target");

   // the LED command follows the display write without a gap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tlast))
      else $error("second backlight result missing");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && !s1_valid_ff))
      else $error("state not cleared by reset");
`endif

endmodule

[tb/sv/indicator_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// LED indicator priority select - command scoreboard
// Keeps a shadow copy of the stored light sources, works out the backlight,
// button and RGB LED commands each request should cause, and checks the
// commands the block returns against them in order.
// ----------------------------------------------------------------------------
package indicator_scoreboard_pkg;

   import lis_pkg::*;

   typedef enum {
      LIT_NONE,
      LIT_ATTENTION,
      LIT_NOTIFY,
      LIT_BATTERY
   } lit_source_type;

   class indicator_scoreboard;

      source_type  battery;
      source_type  notify;
      source_type  attention;
      logic        display_lit;
      result_type  expected_commands[$];
      int unsigned mismatches;

      function new();
         battery     = '0;
         notify      = '0;
         attention   = '0;
         display_lit = 1'b1;
         mismatches  = 0;
      endfunction

      function int pending();
         return expected_commands.size();
      endfunction

      // attention beats notification; battery only shows with the display dark
      function result_type predict_led_command();
         result_type     cmd;
         source_type     pick;
         lit_source_type which;
         logic [7:0]     r;
         logic [7:0]     g;
         logic [7:0]     b;
         cmd        = RESULT_ZERO;
         cmd.target = TARGET_LED;
         pick       = '0;
         which      = LIT_NONE;
         if ((attention.color & RGB_MASK) != 0) begin
            which = LIT_ATTENTION;
            pick  = attention;
         end else if ((notify.color & RGB_MASK) != 0) begin
            which = LIT_NOTIFY;
            pick  = notify;
         end else if (!display_lit && (battery.color & RGB_MASK) != 0) begin
            which = LIT_BATTERY;
            pick  = battery;
         end
         r = pick.color[23:16];
         g = pick.color[15:8];
         b = pick.color[7:0];
         if (which == LIT_BATTERY) begin
            cmd.led_mode   = MODE_STORED;
            cmd.pattern_id = (r > g && r > b) ? PATTERN_BATT_RED : PATTERN_BATT_OTHER;
         end else if (which == LIT_ATTENTION) begin
            cmd.led_mode   = MODE_STORED;
            cmd.pattern_id = PATTERN_ATTENTION;
         end else if (which == LIT_NOTIFY && g != 0 && g >= r && g >= b) begin
            cmd.led_mode   = MODE_STORED;
            cmd.pattern_id = PATTERN_NOTIFY_GRN;
         end else if ({r, g, b} == 24'h0) begin
            cmd.led_mode = MODE_OFF;
         end else if (pick.timed && pick.on_ms != 0 && pick.off_ms != 0) begin
            cmd.led_mode     = MODE_BLINK;
            cmd.blink_color  = pick.color;
            cmd.blink_on_ms  = pick.on_ms;
            cmd.blink_off_ms = pick.off_ms;
         end else begin
            cmd.led_mode = MODE_SOLID;
            cmd.red      = r;
            cmd.green    = g;
            cmd.blue     = b;
         end
         return cmd;
      endfunction

      function void note_request(logic [2:0] func, logic [31:0] color, logic timed,
                                 logic [15:0] on_ms, logic [15:0] off_ms);
         result_type cmd;
         source_type req;
         req.color  = color;
         req.timed  = timed;
         req.on_ms  = on_ms;
         req.off_ms = off_ms;
         cmd        = RESULT_ZERO;
         case (func)
            FUNC_BACKLIGHT: begin
               cmd.target  = TARGET_DISPLAY;
               cmd.level   = color[23:16];
               expected_commands.push_back(cmd);
               display_lit = (color[23:16] != 0);
            end
            FUNC_BUTTONS: begin
               cmd.target = TARGET_BUTTONS;
               cmd.level  = ((color & RGB_MASK) != 0) ? LEVEL_FULL : 8'h00;
               cmd.last   = 1'b1;
               expected_commands.push_back(cmd);
               return;
            end
            FUNC_BATTERY:   battery   = req;
            FUNC_NOTIFY:    notify    = req;
            FUNC_ATTENTION: attention = req;
            default:        return;
         endcase
         cmd      = predict_led_command();
         cmd.last = 1'b1;
         expected_commands.push_back(cmd);
      endfunction

      function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_command(result_type got);
         result_type want;
         bit         ok;
         if (expected_commands.size() == 0) begin
            $display("%0t unexpected command: target %0h level %0h mode %0h pattern %0h",
                     $time, got.target, got.level, got.led_mode, got.pattern_id);
            mismatches++;
            return;
         end
         want = expected_commands.pop_front();
         ok   = 1'b1;
         ok  &= field_ok("target", want.target, got.target);
         ok  &= field_ok("level", want.level, got.level);
         ok  &= field_ok("led_mode", want.led_mode, got.led_mode);
         ok  &= field_ok("pattern_id", want.pattern_id, got.pattern_id);
         ok  &= field_ok("red", want.red, got.red);
         ok  &= field_ok("green", want.green, got.green);
         ok  &= field_ok("blue", want.blue, got.blue);
         ok  &= field_ok("blink_color", want.blink_color, got.blink_color);
         ok  &= field_ok("blink_on_ms", want.blink_on_ms, got.blink_on_ms);
         ok  &= field_ok("blink_off_ms", want.blink_off_ms, got.blink_off_ms);
         ok  &= field_ok("last", want.last, got.last);
         if (!ok) begin
            mismatches++;
         end
      endfunction

   endclass

endpackage

[tb/sv/led_indicator_priority_select_tb.sv]
// ----------------------------------------------------------------------------
// LED indicator priority select - testbench
// Drives light requests into the block and checks every backlight, button
// and RGB LED command it returns against a shadow model of the sources.
// A short directed set covers the priority rules and field extremes, then
// random requests run with bursty idling on both sides, one long receiver
// hold-off to fill the result queue, and one full drain pause.
// ----------------------------------------------------------------------------
module led_indicator_priority_select_tb;

   import lis_pkg::*;
   import indicator_scoreboard_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 12;
   localparam int RANDOM_REQUESTS = 600;
   localparam int QUIET_REQUESTS  = 100;     // tail of the run with no idling
   localparam int BURST_REQUESTS  = 16;      // offered while the receiver holds off
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 8;
   localparam int TIMEOUT_CYCLES  = 200000;

   // request kinds the block drops without a result
   localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  req_tdata;   // argb_color[31:0], flash_timed[32],
                              // flash_on_ms[48:33], flash_off_ms[64:49], zero pad
   logic [2:0]   req_tuser;   // func[2:0]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;   // level, led_mode, pattern_id, red, green, blue,
                              // blink_color, blink_on_ms, blink_off_ms, zero pad
   logic [1:0]   rsp_tuser;   // target[1:0]
   logic         rsp_tlast;

   indicator_scoreboard command_check = new();
   result_type          seen_command;

   bit          quiet;              // no idling on either side
   bit          in_burst;           // sender offers back to back
   bit          hold_off_pending;   // asks the receiver for a long hold-off
   bit          pause_after;        // sender waits for a full drain after next transaction
   int unsigned sender_idle_pct;

   led_indicator_priority_select u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Receiver: stall pressure (0..40 percent) is redrawn per window, stalls have
   // random length. A hold-off request from the stimulus side drops tready for
   // a long stretch so the 4-entry result queue fills and req_tready falls.
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned window_left;
      int unsigned stall_pct;
      rsp_tready  = 1'b0;
      window_left = 0;
      stall_pct   = 0;
      forever begin
         @(posedge clock);
         if (window_left == 0) begin
            window_left = 50;
            stall_pct   = 10 * $urandom_range(0, 4);
         end
         window_left--;
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor: outputs are sampled at the edge, before the block's
   // flops update, so each transaction is seen exactly once.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_command.target       = target_type'(rsp_tuser);
         seen_command.level        = rsp_tdata[7:0];
         seen_command.led_mode     = led_mode_type'(rsp_tdata[9:8]);
         seen_command.pattern_id   = rsp_tdata[13:10];
         seen_command.red          = rsp_tdata[21:14];
         seen_command.green        = rsp_tdata[29:22];
         seen_command.blue         = rsp_tdata[37:30];
         seen_command.blink_color  = rsp_tdata[69:38];
         seen_command.blink_on_ms  = rsp_tdata[85:70];
         seen_command.blink_off_ms = rsp_tdata[101:86];
         seen_command.last         = rsp_tlast;
         command_check.check_command(seen_command);
      end
   end

   // ---------------------------------------------------------------------------
   // Sender. Each call drives one transaction and returns after its acceptance
   // and any idle gap or drain pause. tvalid is dropped only for an idle gap or a
   // drain pause, so back-to-back transactions keep it high without a second assignment.
   // ---------------------------------------------------------------------------
   task automatic send_request(input logic [2:0] func, input logic [31:0] color,
                               input logic timed, input logic [15:0] on_ms,
                               input logic [15:0] off_ms);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'd0, off_ms, on_ms, timed, color};
      do @(posedge clock); while (!req_tready);
      command_check.note_request(func, color, timed, on_ms, off_ms);
      if (pause_after) begin
         pause_after = 1'b0;
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (command_check.pending() != 0) @(posedge clock);
      end else if (!quiet && !in_burst && $urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // colors lean on corner cases: RGB zero with any alpha, one channel lit,
   // near ties between channels, and all ones
   function automatic logic [31:0] random_color();
      logic [7:0] alpha;
      alpha = 8'($urandom);
      case ($urandom_range(0, 6))
         0:       return {alpha, 24'h0};
         1:       return {alpha, 24'(8'($urandom_range(1, 255))) << (8 * $urandom_range(0, 2))};
         2:       return {alpha, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                          8'($urandom_range(0, 3))};
         3:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] random_ms();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_request(output bit known);
      logic [2:0]  func;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         func = FUNC_BACKLIGHT;
      end else if (pick < 33) begin
         func = FUNC_BUTTONS;
      end else if (pick < 53) begin
         func = FUNC_BATTERY;
      end else if (pick < 73) begin
         func = FUNC_NOTIFY;
      end else if (pick < 93) begin
         func = FUNC_ATTENTION;
      end else begin
         func = FUNC_FIRST_UNUSED + 3'($urandom_range(0, 2));
      end
      known = (func < FUNC_FIRST_UNUSED);
      send_request(func, random_color(), 1'($urandom), random_ms(), random_ms());
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus and verdict
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned accepted;
      bit          known;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = '0;
      quiet            = 1'b0;
      in_burst         = 1'b0;
      hold_off_pending = 1'b0;
      pause_after      = 1'b0;
      sender_idle_pct  = 20;
      accepted         = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // dark display, nothing stored: LED off
      send_request(FUNC_BACKLIGHT, 32'h0000_0000, 1'b0, 16'h0000, 16'h0000);
      // buttons: alpha alone does not count as lit
      send_request(FUNC_BUTTONS, 32'h0000_0000, 1'b0, 16'h0000, 16'h0000);
      send_request(FUNC_BUTTONS, 32'hFF00_0000, 1'b1, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_BUTTONS, 32'h0000_0001, 1'b0, 16'h0000, 16'h0000);
      // battery with dark display: red-dominant pattern, then ties go to the other one
      send_request(FUNC_BATTERY, 32'h00FF_0000, 1'b0, 16'h0000, 16'h0000);
      send_request(FUNC_BATTERY, 32'h0080_8000, 1'b0, 16'h0000, 16'h0000);
      send_request(FUNC_BATTERY, 32'hFF00_00FF, 1'b1, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_BATTERY, 32'h00FF_0000, 1'b1, 16'h1234, 16'h4321);
      // lit display hides the battery
      send_request(FUNC_BACKLIGHT, 32'h0001_0000, 1'b0, 16'h0000, 16'h0000);
      // notification: green dominant and green ties pick the green pattern
      send_request(FUNC_NOTIFY, 32'h0000_FF00, 1'b0, 16'h0000, 16'h0000);
      send_request(FUNC_NOTIFY, 32'h0010_1010, 1'b1, 16'h0001, 16'h0001);
      // red dominant, timed with both times set: blink
      send_request(FUNC_NOTIFY, 32'h0010_0F00, 1'b1, 16'h0001, 16'h0001);
      // timed but one time zero: solid
      send_request(FUNC_NOTIFY, 32'h0000_00FF, 1'b1, 16'h0000, 16'd500);
      send_request(FUNC_NOTIFY, 32'h0000_00FF, 1'b1, 16'd500, 16'h0000);
      send_request(FUNC_NOTIFY, 32'h0000_00FF, 1'b0, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_NOTIFY, 32'hFFFF_0000, 1'b1, 16'hFFFF, 16'hFFFF);
      // attention with alpha only is not lit; any RGB bit takes over
      send_request(FUNC_ATTENTION, 32'h0100_0000, 1'b1, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_ATTENTION, 32'h0000_0001, 1'b0, 16'h0000, 16'h0000);
      // unused kinds: dropped, nothing comes back
      send_request(FUNC_FIRST_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_FIRST_UNUSED + 3'd1, 32'h00FF_0000, 1'b0, 16'h0000, 16'h0000);
      send_request(FUNC_FIRST_UNUSED + 3'd2, 32'h0000_FF00, 1'b1, 16'h0001, 16'h0001);
      // clear attention and notification, darken display: battery shows again
      send_request(FUNC_ATTENTION, 32'h0000_0000, 1'b0, 16'h0000, 16'h0000);
      send_request(FUNC_NOTIFY, 32'hFF00_0000, 1'b0, 16'h0000, 16'h0000);
      send_request(FUNC_BACKLIGHT, 32'hFF00_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_BACKLIGHT, 32'hFFFF_FFFF, 1'b0, 16'h0000, 16'h0000);
      send_request(FUNC_BUTTONS, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);

      while (accepted < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 39) == 0) begin
            sender_idle_pct = 10 * $urandom_range(0, 4);
         end
         if (accepted >= RANDOM_REQUESTS - QUIET_REQUESTS) begin
            quiet = 1'b1;
         end
         if (accepted == 200) begin
            // fill the result queue: backlight transactions give two results each
            hold_off_pending = 1'b1;
            in_burst         = 1'b1;
            repeat (BURST_REQUESTS) begin
               send_request(FUNC_BACKLIGHT, random_color(), 1'($urandom), random_ms(),
                            random_ms());
            end
            in_burst = 1'b0;
            accepted += BURST_REQUESTS;
         end
         if (accepted == 400) begin
            pause_after = 1'b1;
         end
         random_request(known);
         if (known) begin
            accepted++;
         end
      end

      // closing transaction drops tvalid and waits for every result
      pause_after = 1'b1;
      send_request(FUNC_BACKLIGHT, random_color(), 1'($urandom), random_ms(), random_ms());
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (command_check.mismatches == 0 && command_check.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
